[sv/isotropic_hooke_stress_assert.svh]
// Assertion macros for the isotropic Hooke stress block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
// No other dependencies.
`ifndef ISOTROPIC_HOOKE_STRESS_ASSERT_SVH
`define ISOTROPIC_HOOKE_STRESS_ASSERT_SVH

// Same-cycle implication.
`define HKS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hks_pkg.sv]
// Shared widths, constants and lane structs for the isotropic Hooke stress block.
// Used by hks_front, hks_div_lane and isotropic_hooke_stress; no dependencies.
package hks_pkg;

  localparam int unsigned NumNormal = 3;
  localparam int unsigned NumShear  = 3;
  localparam int unsigned NumLanes  = NumNormal + NumShear;

  localparam int unsigned EW      = 32;
  localparam int unsigned NuW     = 15;
  localparam int unsigned StrainW = 32;
  localparam int unsigned StressW = 64;

  // Poisson ratio scale S = 2^16
  localparam int unsigned QsBits = 16;
  localparam int unsigned CdW    = QsBits + 1;
  localparam logic [CdW-1:0] QOne = CdW'(65536);

  // |a| fits in 48 bits, E * |a| in 80 bits, divisors in 33 bits
  localparam int unsigned MagW  = 48;
  localparam int unsigned HalfW = MagW / 2;
  localparam int unsigned PartW = EW + HalfW;
  localparam int unsigned ProdW = EW + MagW;
  localparam int unsigned DvW   = 33;
  localparam logic [DvW-1:0] QSquare = DvW'(64'h1_0000_0000);

  // quotient bits resolved by the divider chain
  localparam int unsigned QuoW = 64;

  // register stages: four front, one per quotient bit, round, output
  localparam int unsigned FrontDepth = 4;
  localparam int unsigned PipeDepth  = FrontDepth + QuoW + 2;

  localparam logic [StressW-1:0] StressMax = {1'b0, {(StressW-1){1'b1}}};
  localparam logic [StressW-1:0] StressMin = {1'b1, {(StressW-1){1'b0}}};

  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [DvW-1:0]   dvsr;
    logic             neg;
  } hks_lane_t;

  typedef struct packed {
    logic [QuoW:0] qr;
    logic          neg;
    logic          ovf;
  } hks_quo_t;

endpackage

[sv/hks_front.sv]
// Front end: builds the signed strain combination, its magnitude, the divisor
// and the 80-bit product E*|a| in four register stages. Depends on hks_pkg.
module hks_front import hks_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      model_3d_i,
  input  logic [EW-1:0]             youngs_modulus_i,
  input  logic [NuW-1:0]            poisson_ratio_i,
  input  logic signed [StrainW-1:0] strain_i [NumLanes],
  output hks_lane_t                 lane_o [NumLanes]
);

  localparam int unsigned DiagW = StrainW + CdW + 1;
  localparam int unsigned OffW  = StrainW + NuW + 2;

  // stage 1 inputs
  logic [CdW-1:0]            cd_main;
  logic [CdW-1:0]            cdiag [NumNormal];
  logic signed [StrainW:0]   off_sum [NumNormal];

  // stage 1 registers
  logic signed [DiagW-1:0]   diag_q [NumNormal];
  logic signed [OffW-1:0]    off_q [NumNormal];
  logic signed [StrainW-1:0] shr_q [NumShear];
  logic [2*NuW-1:0]          n2_q;
  logic [CdW-1:0]            spn_q;
  logic [CdW-1:0]            smn_q;
  logic                      mode1_q;
  logic [EW-1:0]             e1_q;

  // stage 2
  logic signed [DiagW-1:0]   sum_d [NumNormal];
  logic [DiagW-1:0]          nabs_d [NumNormal];
  logic [StrainW:0]          sabs_d [NumShear];
  logic [DvW-1:0]            dmain_d;
  logic [DvW-1:0]            dshear_d;
  logic [MagW-1:0]           mag2_q [NumLanes];
  logic                      neg2_q [NumLanes];
  logic [DvW-1:0]            dv2_q [NumLanes];
  logic [EW-1:0]             e2_q;

  // stage 3
  logic [PartW-1:0]          lo3_q [NumLanes];
  logic [PartW-1:0]          hi3_q [NumLanes];
  logic                      neg3_q [NumLanes];
  logic [DvW-1:0]            dv3_q [NumLanes];

  // stage 4
  hks_lane_t                 lane4_q [NumLanes];

  always_comb begin
    cd_main  = model_3d_i ? (QOne - CdW'(poisson_ratio_i)) : QOne;
    cdiag[0] = cd_main;
    cdiag[1] = cd_main;
    // plane mode z lane carries the shear strain unscaled
    cdiag[2] = model_3d_i ? cd_main : CdW'(1);
    off_sum[0] = model_3d_i ? ((StrainW+1)'(strain_i[1]) + (StrainW+1)'(strain_i[2]))
                            : (StrainW+1)'(strain_i[1]);
    off_sum[1] = model_3d_i ? ((StrainW+1)'(strain_i[0]) + (StrainW+1)'(strain_i[2]))
                            : (StrainW+1)'(strain_i[0]);
    off_sum[2] = model_3d_i ? ((StrainW+1)'(strain_i[0]) + (StrainW+1)'(strain_i[1]))
                            : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumNormal; l++) begin
        diag_q[l] <= DiagW'($signed({1'b0, cdiag[l]})) * DiagW'(strain_i[l]);
        off_q[l]  <= OffW'($signed({1'b0, poisson_ratio_i})) * OffW'(off_sum[l]);
      end
      for (int k = 0; k < NumShear; k++) begin
        shr_q[k] <= model_3d_i ? strain_i[NumNormal+k] : '0;
      end
      n2_q    <= (2*NuW)'(poisson_ratio_i) * (2*NuW)'(poisson_ratio_i);
      spn_q   <= QOne + CdW'(poisson_ratio_i);
      smn_q   <= QOne - {1'b0, poisson_ratio_i, 1'b0};
      mode1_q <= model_3d_i;
      e1_q    <= youngs_modulus_i;
    end
  end

  always_comb begin
    for (int l = 0; l < NumNormal; l++) begin
      sum_d[l]  = diag_q[l] + DiagW'(off_q[l]);
      nabs_d[l] = sum_d[l][DiagW-1] ? DiagW'(-sum_d[l]) : DiagW'(sum_d[l]);
    end
    for (int k = 0; k < NumShear; k++) begin
      sabs_d[k] = shr_q[k][StrainW-1] ? (StrainW+1)'(-(StrainW+1)'(shr_q[k]))
                                      : (StrainW+1)'(shr_q[k]);
    end
    dmain_d  = mode1_q ? DvW'((2*CdW)'(spn_q) * (2*CdW)'(smn_q))
                       : (QSquare - DvW'(n2_q));
    dshear_d = DvW'({spn_q, 1'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumNormal; l++) begin
        mag2_q[l] <= nabs_d[l][MagW-1:0];
        neg2_q[l] <= sum_d[l][DiagW-1];
      end
      for (int k = 0; k < NumShear; k++) begin
        mag2_q[NumNormal+k] <= MagW'(sabs_d[k]);
        neg2_q[NumNormal+k] <= shr_q[k][StrainW-1];
        dv2_q[NumNormal+k]  <= dshear_d;
      end
      dv2_q[0] <= dmain_d;
      dv2_q[1] <= dmain_d;
      dv2_q[2] <= mode1_q ? dmain_d : dshear_d;
      e2_q     <= e1_q;
    end
  end

  // split E*|a| into two 32x24 partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        lo3_q[l]  <= PartW'(e2_q) * PartW'(mag2_q[l][HalfW-1:0]);
        hi3_q[l]  <= PartW'(e2_q) * PartW'(mag2_q[l][MagW-1:HalfW]);
        neg3_q[l] <= neg2_q[l];
        dv3_q[l]  <= dv2_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        lane4_q[l].prod <= {hi3_q[l], HalfW'(0)} + ProdW'(lo3_q[l]);
        lane4_q[l].dvsr <= dv3_q[l];
        lane4_q[l].neg  <= neg3_q[l];
      end
    end
  end

  assign lane_o = lane4_q;

endmodule

[sv/hks_div_lane.sv]
// One lane of the restoring divider: one quotient bit per stage, then a
// round-half-up stage on the remainder. Depends on hks_pkg.
module hks_div_lane import hks_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  hks_lane_t lane_i,
  output hks_quo_t  quo_o
);

  localparam int unsigned LastStep = QuoW - 1;

  logic [DvW-1:0]  rem_in;
  logic [QuoW-1:0] shf_in;
  logic            ovf_in;

  logic [DvW-1:0]  rem_q [QuoW];
  logic [QuoW-1:0] shf_q [QuoW];
  logic [DvW-1:0]  dv_q  [QuoW];
  logic            neg_q [QuoW];
  logic            ovf_q [QuoW];

  logic            up_d;
  hks_quo_t        quo_q;

  // numerator is prod * 2^16; its top 32 bits seed the remainder
  assign rem_in = DvW'(lane_i.prod[ProdW-1:QuoW-QsBits]);
  assign shf_in = {lane_i.prod[QuoW-QsBits-1:0], QsBits'(0)};
  // quotient of 2^64 or more always saturates
  assign ovf_in = rem_in >= lane_i.dvsr;

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [DvW-1:0]  rem_prev;
    logic [QuoW-1:0] shf_prev;
    logic [DvW-1:0]  dv_prev;
    logic            neg_prev;
    logic            ovf_prev;
    logic [DvW:0]    trial;
    logic [DvW:0]    diff;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_prev = rem_in;
      assign shf_prev = shf_in;
      assign dv_prev  = lane_i.dvsr;
      assign neg_prev = lane_i.neg;
      assign ovf_prev = ovf_in;
    end else begin : g_next
      assign rem_prev = rem_q[k-1];
      assign shf_prev = shf_q[k-1];
      assign dv_prev  = dv_q[k-1];
      assign neg_prev = neg_q[k-1];
      assign ovf_prev = ovf_q[k-1];
    end

    assign trial = {rem_prev, shf_prev[QuoW-1]};
    assign take  = trial >= {1'b0, dv_prev};
    assign diff  = trial - {1'b0, dv_prev};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[DvW-1:0] : trial[DvW-1:0];
        shf_q[k] <= {shf_prev[QuoW-2:0], take};
        dv_q[k]  <= dv_prev;
        neg_q[k] <= neg_prev;
        ovf_q[k] <= ovf_prev;
      end
    end
  end

  // round half away from zero on the magnitude
  assign up_d = {rem_q[LastStep], 1'b0} >= {1'b0, dv_q[LastStep]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q.qr  <= {1'b0, shf_q[LastStep]} + (QuoW+1)'(up_d);
      quo_q.neg <= neg_q[LastStep];
      quo_q.ovf <= ovf_q[LastStep];
    end
  end

  assign quo_o = quo_q;

endmodule

[sv/isotropic_hooke_stress.sv]
// Top level of the isotropic Hooke stress pipeline: front end, six divider
// lanes, saturation and output register. Depends on hks_pkg, hks_front,
// hks_div_lane and isotropic_hooke_stress_assert.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one material point per
//   transaction: E, Poisson ratio and six strain words. Output channel
//   (out_valid_o / out_stall_i) returns six stress words and a saturation
//   flag, exactly one result transaction per input transaction, in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes model_3d; it is
//   always ready and must only be written while the pipeline is empty.
// Pipeline: 4 front stages, 64 divider stages at one quotient bit each, a
//   rounding stage and the output register. Throughput: one transaction per
//   cycle while no result is held in the output register by out_stall_i.
// Stall: the whole pipeline advances on one enable. While a result sits in
//   the output register and out_stall_i is high, every stage holds and
//   in_stall_o is raised in the same cycle; nothing is dropped or repeated.
// Reset: rst_ni clears all valid bits and returns model_3d to plane stress.
//   Payload registers are not reset.
// Plane stress mode drives stress_fourth..sixth to zero.

`include "isotropic_hooke_stress_assert.svh"

module isotropic_hooke_stress import hks_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_model_3d_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [EW-1:0]             youngs_modulus_i,
  input  logic [NuW-1:0]            poisson_ratio_i,
  input  logic signed [StrainW-1:0] strain_xx_i,
  input  logic signed [StrainW-1:0] strain_yy_i,
  input  logic signed [StrainW-1:0] strain_third_i,
  input  logic signed [StrainW-1:0] strain_fourth_i,
  input  logic signed [StrainW-1:0] strain_fifth_i,
  input  logic signed [StrainW-1:0] strain_sixth_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [StressW-1:0] stress_xx_o,
  output logic signed [StressW-1:0] stress_yy_o,
  output logic signed [StressW-1:0] stress_third_o,
  output logic signed [StressW-1:0] stress_fourth_o,
  output logic signed [StressW-1:0] stress_fifth_o,
  output logic signed [StressW-1:0] stress_sixth_o,
  output logic                      saturated_o
);

  logic                      model_3d_q;
  logic                      advance;
  logic [PipeDepth-1:0]      vld_q;

  logic signed [StrainW-1:0] strain [NumLanes];
  hks_lane_t                 lane [NumLanes];
  hks_quo_t                  quo [NumLanes];

  logic [StressW-1:0]        limit_d [NumLanes];
  logic [StressW-1:0]        mag_d [NumLanes];
  logic [StressW-1:0]        stress_d [NumLanes];
  logic [NumLanes-1:0]       clip_d;
  logic [StressW-1:0]        stress_q [NumLanes];
  logic                      sat_q;
  logic                      at_bound;

  // configuration: always ready, keep bit 0 of the write data
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_3d_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      model_3d_q <= cfg_model_3d_i;
    end
  end

  // one enable for every stage: hold only when a finished result is blocked
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[PipeDepth-1];

  assign strain[0] = strain_xx_i;
  assign strain[1] = strain_yy_i;
  assign strain[2] = strain_third_i;
  assign strain[3] = strain_fourth_i;
  assign strain[4] = strain_fifth_i;
  assign strain[5] = strain_sixth_i;

  hks_front u_front (
    .clk_i            (clk_i),
    .en_i             (advance),
    .model_3d_i       (model_3d_q),
    .youngs_modulus_i (youngs_modulus_i),
    .poisson_ratio_i  (poisson_ratio_i),
    .strain_i         (strain),
    .lane_o           (lane)
  );

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    hks_div_lane u_div (
      .clk_i  (clk_i),
      .en_i   (advance),
      .lane_i (lane[l]),
      .quo_o  (quo[l])
    );
  end

  // clip the rounded magnitude to the signed range, then apply the sign
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      limit_d[l]  = quo[l].neg ? StressMin : StressMax;
      clip_d[l]   = quo[l].ovf || (quo[l].qr > {1'b0, limit_d[l]});
      mag_d[l]    = clip_d[l] ? limit_d[l] : quo[l].qr[StressW-1:0];
      stress_d[l] = quo[l].neg ? (StressW'(0) - mag_d[l]) : mag_d[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stress_q <= stress_d;
      sat_q    <= |clip_d;
    end
  end

  assign stress_xx_o     = stress_q[0];
  assign stress_yy_o     = stress_q[1];
  assign stress_third_o  = stress_q[2];
  assign stress_fourth_o = stress_q[3];
  assign stress_fifth_o  = stress_q[4];
  assign stress_sixth_o  = stress_q[5];
  assign saturated_o     = sat_q;

  always_comb begin
    at_bound = 1'b0;
    for (int l = 0; l < NumLanes; l++) begin
      at_bound = at_bound || (stress_q[l] == StressMax) || (stress_q[l] == StressMin);
    end
  end

  `HKS_ASSERT_IMPL(a_stall_needs_result, in_stall_o, out_valid_o, "input stalled with no result held")
  `HKS_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, vld_q[0], "accepted transaction lost at entry")
  `HKS_ASSERT_IMPL(a_sat_at_bound, out_valid_o && saturated_o, at_bound, "saturated flag without clipped stress")
  `HKS_ASSERT_IMPL(a_round_range, vld_q[PipeDepth-2] && !quo[0].ovf, !quo[0].qr[QuoW] || (quo[0].qr[QuoW-1:0] == '0), "rounded quotient out of range")

endmodule

[tb/isotropic_hooke_stress_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for isotropic_hooke_stress: corner and random points
// go through both elasticity modes under changing backpressure.
// Depends on hks_pkg and the isotropic_hooke_stress RTL.

module isotropic_hooke_stress_tb import hks_pkg::*; ();

  // Elasticity mode held in the single configuration register
  typedef enum bit {PLANE_STRESS = 1'b0, FULL_3D = 1'b1} elast_mode_e;

  // Poisson ratio scale, S = 2^16
  localparam longint QScale = 65536;

  // One material point as it crosses the input channel. Strain order:
  // xx, yy, third, fourth, fifth, sixth.
  typedef struct packed {
    logic [EW-1:0]               modulus;
    logic [NuW-1:0]              nu;
    logic [5:0][StrainW-1:0]     strain;
  } point_t;

  // One stress result. Stress order matches the strain order.
  typedef struct packed {
    logic [5:0][StressW-1:0]     stress;
    logic                        clipped;
  } stress_t;

  // Predict the stress for each accepted point and hold it until the
  // matching output transaction shows up.
  class hooke_checker;
    stress_t expected_stress[$];
    int      mismatches;

    // round(E * S * a / d), ties away from zero, clipped to signed 64 bits
    function logic [StressW-1:0] scaled_quotient(logic [EW-1:0] e, longint a,
                                                 longint d, inout bit clip);
      logic [127:0] num;
      logic [127:0] quo;
      logic [127:0] rem;
      logic [127:0] dvsr;
      logic [63:0]  mag;
      logic [63:0]  limit;
      bit           neg;
      neg  = (a < 0);
      mag  = neg ? 64'(-a) : 64'(a);
      num  = 128'(e);
      num  = (num * 128'(mag)) << QsBits;
      dvsr = 128'(d);
      quo  = num / dvsr;
      rem  = num % dvsr;
      if (rem >= dvsr - rem) quo = quo + 128'd1;
      limit = neg ? StressMin : StressMax;
      if (quo > 128'(limit)) begin
        clip = 1'b1;
        quo  = 128'(limit);
      end
      return neg ? -quo[63:0] : quo[63:0];
    endfunction

    function stress_t hooke_stress(point_t p, elast_mode_e mode);
      stress_t r;
      longint  n;
      longint  x;
      longint  y;
      longint  z;
      longint  dshear;
      longint  dnorm;
      bit      clip;
      int      k;
      n      = longint'(p.nu);
      x      = longint'($signed(p.strain[0]));
      y      = longint'($signed(p.strain[1]));
      z      = longint'($signed(p.strain[2]));
      clip   = 1'b0;
      r      = '0;
      // shear divisor is the same in both modes
      dshear = 2 * (QScale + n);
      if (mode == FULL_3D) begin
        dnorm = (QScale + n) * (QScale - 2 * n);
        r.stress[0] = scaled_quotient(p.modulus, (QScale - n) * x + n * (y + z), dnorm, clip);
        r.stress[1] = scaled_quotient(p.modulus, (QScale - n) * y + n * (x + z), dnorm, clip);
        r.stress[2] = scaled_quotient(p.modulus, (QScale - n) * z + n * (x + y), dnorm, clip);
        for (k = 3; k < 6; k++)
          r.stress[k] = scaled_quotient(p.modulus, longint'($signed(p.strain[k])),
                                        dshear, clip);
      end else begin
        // plane stress: the three upper shear outputs stay zero
        dnorm = QScale * QScale - n * n;
        r.stress[0] = scaled_quotient(p.modulus, QScale * x + n * y, dnorm, clip);
        r.stress[1] = scaled_quotient(p.modulus, n * x + QScale * y, dnorm, clip);
        r.stress[2] = scaled_quotient(p.modulus, z, dshear, clip);
      end
      r.clipped = clip;
      return r;
    endfunction

    function void note_point(point_t p, elast_mode_e mode);
      expected_stress.push_back(hooke_stress(p, mode));
    endfunction

    function void check_stress(stress_t got);
      stress_t want;
      int      k;
      if (expected_stress.size() == 0) begin
        $display("%0t: stress result with nothing pending: %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_stress.pop_front();
      for (k = 0; k < 6; k++) begin
        if (got.stress[k] !== want.stress[k]) begin
          $display("%0t: stress[%0d] expected %0d actual %0d", $time, k,
                   $signed(want.stress[k]), $signed(got.stress[k]));
          mismatches++;
        end
      end
      if (got.clipped !== want.clipped) begin
        $display("%0t: saturated expected %b actual %b", $time, want.clipped, got.clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic                      cfg_model_3d_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [EW-1:0]             youngs_modulus_i;
  logic [NuW-1:0]            poisson_ratio_i;
  logic signed [StrainW-1:0] strain_xx_i;
  logic signed [StrainW-1:0] strain_yy_i;
  logic signed [StrainW-1:0] strain_third_i;
  logic signed [StrainW-1:0] strain_fourth_i;
  logic signed [StrainW-1:0] strain_fifth_i;
  logic signed [StrainW-1:0] strain_sixth_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [StressW-1:0] stress_xx_o;
  logic signed [StressW-1:0] stress_yy_o;
  logic signed [StressW-1:0] stress_third_o;
  logic signed [StressW-1:0] stress_fourth_o;
  logic signed [StressW-1:0] stress_fifth_o;
  logic signed [StressW-1:0] stress_sixth_o;
  logic                      saturated_o;

  hooke_checker ledger;
  elast_mode_e  mode;
  // Percent chance, per cycle, of a sender gap and of a receiver stall
  int           gap_pct;
  int           stall_pct;

  isotropic_hooke_stress uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_model_3d_i   (cfg_model_3d_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .youngs_modulus_i (youngs_modulus_i),
    .poisson_ratio_i  (poisson_ratio_i),
    .strain_xx_i      (strain_xx_i),
    .strain_yy_i      (strain_yy_i),
    .strain_third_i   (strain_third_i),
    .strain_fourth_i  (strain_fourth_i),
    .strain_fifth_i   (strain_fifth_i),
    .strain_sixth_i   (strain_sixth_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .stress_xx_o      (stress_xx_o),
    .stress_yy_o      (stress_yy_o),
    .stress_third_o   (stress_third_o),
    .stress_fourth_o  (stress_fourth_o),
    .stress_fifth_o   (stress_fifth_o),
    .stress_sixth_o   (stress_sixth_o),
    .saturated_o      (saturated_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output side: check every accepted result, then pick the next stall.
  // Values sampled here are the ones from before the edge, so the check
  // does not race the block's own register updates.
  always @(posedge clk_i) begin : result_side
    stress_t got;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.stress[0] = stress_xx_o;
      got.stress[1] = stress_yy_o;
      got.stress[2] = stress_third_o;
      got.stress[3] = stress_fourth_o;
      got.stress[4] = stress_fifth_o;
      got.stress[5] = stress_sixth_o;
      got.clipped   = saturated_o;
      ledger.check_stress(got);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic point_t make_point(logic [31:0] e, logic [14:0] nu,
                                        logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                        logic [31:0] d, logic [31:0] f, logic [31:0] g);
    point_t p;
    p.modulus = e;
    p.nu      = nu;
    p.strain  = {g, f, d, c, b, a};
    return p;
  endfunction

  // Random point drawn from one of a few shapes: full range, strains near
  // zero (few clips), small modulus, or stiff material with nu near one half.
  function automatic point_t random_point();
    point_t p;
    int     k;
    p.modulus = $urandom();
    p.nu      = NuW'($urandom_range(32767));
    for (k = 0; k < 6; k++) p.strain[k] = $urandom();
    case ($urandom_range(3))
      0: begin
        // keep the full-range draw
      end
      1: begin
        for (k = 0; k < 6; k++) p.strain[k] = $urandom_range(2097151) - 1048576;
      end
      2: begin
        p.modulus = $urandom_range(65535);
      end
      default: begin
        p.nu      = NuW'(32767 - $urandom_range(15));
        p.modulus = ~32'($urandom_range(255));
      end
    endcase
    return p;
  endfunction

  // Present one point, with random gaps before it, and hold it until the
  // input transaction completes. Valid stays high into the next point when
  // no gap is drawn.
  task automatic send_point(point_t p);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    youngs_modulus_i <= p.modulus;
    poisson_ratio_i  <= p.nu;
    strain_xx_i      <= p.strain[0];
    strain_yy_i      <= p.strain[1];
    strain_third_i   <= p.strain[2];
    strain_fourth_i  <= p.strain[3];
    strain_fifth_i   <= p.strain[4];
    strain_sixth_i   <= p.strain[5];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.note_point(p, mode);
  endtask

  // Drop valid and wait for every pending result to come back; every point
  // yields exactly one result, so the pipeline is empty afterwards.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (ledger.expected_stress.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_mode(elast_mode_e m);
    cfg_valid_i    <= 1'b1;
    cfg_model_3d_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mode = m;
  endtask

  // Corner points: field extremes, both saturation directions, rounding
  // ties on tiny values, zero modulus, and nonzero upper shears so that
  // plane mode must zero them.
  task automatic send_corner_points();
    send_point(make_point(32'hFFFF_FFFF, 15'h7FFF, 0, 0, 0, 0, 0, 0));
    send_point(make_point(32'hFFFF_FFFF, 15'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_point(make_point(32'hFFFF_FFFF, 15'h7FFF, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_point(make_point(32'hFFFF_FFFF, 15'h0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_point(make_point(32'd1, 15'h0000, 1, 1, 1, 1, 1, 1));
    send_point(make_point(32'd1, 15'h0000, -1, -1, -1, -1, -1, -1));
    send_point(make_point(32'd3, 15'h0001, 1, -1, 2, -2, 3, -3));
    send_point(make_point(32'd0, 15'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_point(make_point(32'h8000_0000, 15'h4000, 32'h2000_0000, 0, 0,
                          32'h2000_0000, 32'hE000_0000, 0));
    send_point(make_point(32'hAAAA_AAAA, 15'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    send_point(make_point(32'h5555_5555, 15'h2AAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    send_point(make_point(32'hFFFF_FFFF, 15'h0000, 0, 0, 32'h8000_0000, 0, 0, 0));
  endtask

  // Random phases: (sender gap %, receiver stall %) per phase pair
  int phase_gap[4]   = '{0, 54, 0, 27};
  int phase_stall[4] = '{0, 0, 54, 27};

  initial begin
    int ph;
    ledger           = new();
    mode             = PLANE_STRESS;
    gap_pct          = 0;
    stall_pct        = 0;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_model_3d_i   = PLANE_STRESS;
    in_valid_i       = 1'b0;
    out_stall_i      = 1'b0;
    youngs_modulus_i = '0;
    poisson_ratio_i  = '0;
    strain_xx_i      = '0;
    strain_yy_i      = '0;
    strain_third_i   = '0;
    strain_fourth_i  = '0;
    strain_fifth_i   = '0;
    strain_sixth_i   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners in both modes with no backpressure
    set_mode(PLANE_STRESS);
    send_corner_points();
    drain_pipeline();
    set_mode(FULL_3D);
    send_corner_points();
    drain_pipeline();

    // Random points: each backpressure pattern once per mode, the mode
    // changing only while the pipeline is empty
    for (ph = 0; ph < 8; ph++) begin
      set_mode(ph[0] ? FULL_3D : PLANE_STRESS);
      gap_pct   = phase_gap[ph / 2];
      stall_pct = phase_stall[ph / 2];
      repeat (62) send_point(random_point());
      drain_pipeline();
    end

    // Let the pipeline run out, catching any stray result
    repeat (PipeDepth + 8) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.expected_stress.size() == 0) begin
      $display("isotropic_hooke_stress_tb OK");
    end else begin
      $display("isotropic_hooke_stress_tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("isotropic_hooke_stress_tb NOT OK");
    $finish;
  end

endmodule
